// ----- sv/utd_pkg.sv -----
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// Used by utd_front, utd_queue, utd_back and utf8_to_ucs2_decoder_core.
package utd_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    localparam logic [2:0]  LEAD2_TAG = 3'b110;
    localparam logic [3:0]  LEAD3_TAG = 4'hE;
    localparam logic [10:0] MIN_TWO   = 11'h080;
    localparam logic [15:0] MIN_THREE = 16'h0800;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_utd_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic [1:0]  rejected_bytes;
    } t_utd_out;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_ascii;
        logic       is_cont;
        logic       end_of_text;
    } t_utd_cls;

    typedef struct packed {
        logic     valid;
        t_utd_cls item;
    } t_utd_push;

endpackage

// ----- sv/utf8_to_ucs2_decoder_core.sv -----
// UTF-8 to UCS-2 decoder core. Takes one byte per clock while o_in_stall is low, through a
// front end that classifies it into a QUEUE_DEPTH-entry queue; the back end drains one byte
// per clock, unless a held result is stalled, into the output register, so the sustained
// rate is one byte per cycle. Throughput is set by the back end's single decode step per
// byte; the queue absorbs output stalls, and every result is registered before it leaves.
module utf8_to_ucs2_decoder_core import utd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_utd_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_utd_out o_out_data
);

    t_utd_push push;
    logic      q_full;
    logic      q_valid;
    t_utd_cls  q_item;
    logic      q_pop;

    utd_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    utd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    utd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/utd_front.sv -----
// Front end: input handshake and byte classification.
// Depends on utd_pkg; feeds utd_queue.
module utd_front import utd_pkg::*; (
    input  logic      i_in_valid,
    input  t_utd_in   i_in_data,
    input  logic      i_full,
    output logic      o_in_stall,
    output t_utd_push o_push
);

    assign o_in_stall            = i_full;
    assign o_push.valid          = i_in_valid && !i_full;
    assign o_push.item.text_byte = i_in_data.text_byte;
    assign o_push.item.is_ascii  = !i_in_data.text_byte[7];
    assign o_push.item.is_cont   = (i_in_data.text_byte[7:6] == 2'b10);
    assign o_push.item.end_of_text = i_in_data.end_of_text;

endmodule

// ----- sv/utd_queue.sv -----
// Short queue of classified bytes between front and back ends.
// Depends on utd_pkg.
module utd_queue import utd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_utd_push i_push,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_utd_cls  o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_utd_cls        r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;

    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
`endif

endmodule

// ----- sv/utd_back.sv -----
// Back end: sequence decoding state and the output register.
// Depends on utd_pkg; drains utd_queue.
module utd_back import utd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_utd_cls i_q_item,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_utd_out o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ONE,
        S_TWO
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [7:0]  r_lead;
    logic [7:0]  n_lead;
    logic [5:0]  r_first;
    logic [5:0]  n_first;
    logic        r_out_valid;
    t_utd_out    r_out;
    logic        emit;
    t_utd_out    res;
    logic [10:0] val2;
    logic [15:0] val3;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign val2        = {r_lead[4:0], i_q_item.text_byte[5:0]};
    assign val3        = {r_lead[3:0], r_first, i_q_item.text_byte[5:0]};

    always_comb begin
        n_state = r_state;
        n_lead  = r_lead;
        n_first = r_first;
        emit    = 1'b0;
        res     = '0;
        case (r_state)
            S_ONE: begin
                emit = 1'b1;
                if (!i_q_item.is_cont) begin
                    res.status         = ST_INVALID;
                    res.rejected_bytes = 2'd2;
                end else if (r_lead[7:5] == LEAD2_TAG) begin
                    if (val2 >= MIN_TWO) begin
                        res.code_unit = 16'(val2);
                        res.status    = ST_OK;
                    end else begin
                        res.status         = ST_INVALID;
                        res.rejected_bytes = 2'd2;
                    end
                end else if (i_q_item.end_of_text) begin
                    res.status         = ST_TRUNC;
                    res.rejected_bytes = 2'd2;
                end else begin
                    emit    = 1'b0;
                    n_first = i_q_item.text_byte[5:0];
                    n_state = S_TWO;
                end
            end
            S_TWO: begin
                emit = 1'b1;
                if (i_q_item.is_cont && r_lead[7:4] == LEAD3_TAG && val3 >= MIN_THREE) begin
                    res.code_unit = val3;
                    res.status    = ST_OK;
                end else begin
                    res.status         = ST_INVALID;
                    res.rejected_bytes = 2'd3;
                end
            end
            default: begin
                emit = 1'b1;
                if (i_q_item.is_ascii) begin
                    res.code_unit = {8'h00, i_q_item.text_byte};
                    res.status    = ST_OK;
                end else if (i_q_item.end_of_text) begin
                    res.status         = ST_TRUNC;
                    res.rejected_bytes = 2'd1;
                end else begin
                    emit    = 1'b0;
                    n_lead  = i_q_item.text_byte;
                    n_state = S_ONE;
                end
            end
        endcase
        if (emit) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state <= n_state;
                r_lead  <= n_lead;
                r_first <= n_first;
                if (emit) begin
                    r_out <= res;
                end
                r_out_valid <= emit || (r_out_valid && i_out_stall);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_ok_no_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_OK) |-> r_out.rejected_bytes == 2'd0)
        else $error("decoded result carries a reject count");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status == ST_OK || r_out.status == ST_INVALID
                         || r_out.status == ST_TRUNC))
        else $error("status out of range");
    a_idle_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit) |=> r_state == S_IDLE)
        else $error("sequence still open after a result");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for utf8_to_ucs2_decoder_core: directed and random UTF-8 byte
// streams under random sender gaps and receiver stalls, checked against a byte-level decoder.
// Depends on utd_pkg and the RTL under sv/.
module tb import utd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 650;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_utd_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_utd_out o_out_data;

    t_utd_in  byte_stream_q[$];
    t_utd_out decoded_q[$];

    logic [1:0] held_cnt   = 2'd0;
    logic [7:0] lead_reg   = 8'd0;
    logic [5:0] first_bits = 6'd0;

    bit          req_fire     = 1'b0;
    bit          unit_fire    = 1'b0;
    int          bytes_taken  = 0;
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    logic [15:0] stall_cyc    = '0;

    utf8_to_ucs2_decoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit decode_byte(input t_utd_in req, output t_utd_out res);
        logic [7:0]  cb;
        logic [15:0] val;
        bit          done;
        cb   = req.text_byte ^ 8'h80;
        res  = '0;
        done = 1'b1;
        case (held_cnt)
            2'd1: begin
                if (cb[7:6] != 2'b00) begin
                    res.status         = ST_INVALID;
                    res.rejected_bytes = 2'd2;
                end else if (lead_reg[7:5] == LEAD2_TAG) begin
                    val = {5'd0, lead_reg[4:0], cb[5:0]};
                    if (val[10:0] >= MIN_TWO) begin
                        res.code_unit = val;
                        res.status    = ST_OK;
                    end else begin
                        res.status         = ST_INVALID;
                        res.rejected_bytes = 2'd2;
                    end
                end else if (req.end_of_text) begin
                    res.status         = ST_TRUNC;
                    res.rejected_bytes = 2'd2;
                end else begin
                    first_bits = cb[5:0];
                    held_cnt   = 2'd2;
                    done       = 1'b0;
                end
            end
            2'd2: begin
                val = {lead_reg[3:0], first_bits, cb[5:0]};
                if (cb[7:6] == 2'b00 && lead_reg[7:4] == LEAD3_TAG && val >= MIN_THREE) begin
                    res.code_unit = val;
                    res.status    = ST_OK;
                end else begin
                    res.status         = ST_INVALID;
                    res.rejected_bytes = 2'd3;
                end
            end
            default: begin
                if (req.text_byte < 8'h80) begin
                    res.code_unit = {8'd0, req.text_byte};
                    res.status    = ST_OK;
                end else if (req.end_of_text) begin
                    res.status         = ST_TRUNC;
                    res.rejected_bytes = 2'd1;
                end else begin
                    lead_reg   = req.text_byte;
                    first_bits = 6'd0;
                    held_cnt   = 2'd1;
                    done       = 1'b0;
                end
            end
        endcase
        if (done) begin
            held_cnt   = 2'd0;
            lead_reg   = 8'd0;
            first_bits = 6'd0;
        end
        return done;
    endfunction

    task automatic push_req(input logic [7:0] b, input bit eot);
        t_utd_in req;
        req.text_byte   = b;
        req.end_of_text = eot;
        byte_stream_q.push_back(req);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] non_cont_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10)
            b[6] = 1'b1;
        return b;
    endfunction

    task automatic add_sequence();
        int         kind;
        bit         eot;
        logic [7:0] lead;
        kind = $urandom_range(0, 19);
        eot  = ($urandom_range(0, 7) == 0);
        case (kind)
            0, 1, 2, 3: push_req(8'($urandom_range(0, 127)), eot);
            4, 5, 6: begin
                push_req(8'hC2 + 8'($urandom_range(0, 29)), 1'b0);
                push_req(cont_byte(), eot);
            end
            7, 8, 9: begin
                lead = 8'hE0 | 8'($urandom_range(0, 15));
                push_req(lead, 1'b0);
                if (lead == 8'hE0)
                    push_req(8'hA0 | 8'($urandom_range(0, 31)), 1'b0);
                else
                    push_req(cont_byte(), 1'b0);
                push_req(cont_byte(), eot);
            end
            10: begin
                push_req(8'hC0 | 8'($urandom_range(0, 1)), 1'b0);
                push_req(cont_byte(), eot);
            end
            11: begin
                push_req(8'hE0, 1'b0);
                push_req(8'h80 | 8'($urandom_range(0, 31)), 1'b0);
                push_req(cont_byte(), eot);
            end
            12: begin
                push_req(8'hC0 + 8'($urandom_range(0, 47)), 1'b0);
                push_req(non_cont_byte(), eot);
            end
            13: begin
                push_req(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
                push_req(cont_byte(), 1'b0);
                push_req(non_cont_byte(), eot);
            end
            14: begin
                if ($urandom_range(0, 1) == 0)
                    push_req(cont_byte(), 1'b0);
                else
                    push_req(8'hF0 | 8'($urandom_range(0, 15)), 1'b0);
                push_req(8'($urandom_range(0, 255)), 1'b0);
                push_req(8'($urandom_range(0, 255)), eot);
            end
            15: begin
                if ($urandom_range(0, 1) == 0) begin
                    push_req(8'h80 | 8'($urandom_range(0, 127)), 1'b1);
                end else begin
                    push_req(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
                    push_req(cont_byte(), 1'b1);
                end
            end
            default: push_req(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        endcase
    endtask

    initial begin
        push_req(8'h00, 1'b0);
        push_req(8'h7F, 1'b1);
        push_req(8'hC2, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'hE0, 1'b0);
        push_req(8'hA0, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'hEF, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hBF, 1'b1);
        push_req(8'hC1, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hE0, 1'b0);
        push_req(8'h9F, 1'b0);
        push_req(8'hBF, 1'b0);
        push_req(8'hC2, 1'b0);
        push_req(8'h41, 1'b1);
        push_req(8'h80, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'hF0, 1'b0);
        push_req(8'h90, 1'b0);
        push_req(8'h80, 1'b0);
        push_req(8'hFF, 1'b1);
        push_req(8'hE1, 1'b0);
        push_req(8'h80, 1'b1);
        while (byte_stream_q.size() < RANDOM_BYTES + 26)
            add_sequence();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && decoded_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // advance on acceptance, hold a stalled request, idle in gaps between bursts
    always @(negedge i_clk) begin
        if (i_rst_n && (req_fire || !i_in_valid)) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (byte_stream_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= byte_stream_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 16'd1;
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_cyc[8:7])
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= ($urandom_range(0, 1) == 0);
                2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ((stall_cyc % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_units
        t_utd_out want;
        req_fire  = i_rst_n && i_in_valid && !o_in_stall;
        unit_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (req_fire) begin
            bytes_taken++;
            if (decode_byte(i_in_data, want))
                decoded_q.push_back(want);
        end
        if (unit_fire) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result code_unit %h status %0d rejected_bytes %0d",
                       o_out_data.code_unit, o_out_data.status, o_out_data.rejected_bytes);
                mismatch_cnt++;
            end else begin
                want = decoded_q.pop_front();
                if (o_out_data.code_unit !== want.code_unit) begin
                    $error("code_unit expected %h actual %h",
                           want.code_unit, o_out_data.code_unit);
                    mismatch_cnt++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_out_data.status);
                    mismatch_cnt++;
                end
                if (o_out_data.rejected_bytes !== want.rejected_bytes) begin
                    $error("rejected_bytes expected %0d actual %0d",
                           want.rejected_bytes, o_out_data.rejected_bytes);
                    mismatch_cnt++;
                end
            end
        end
        if (req_fire || unit_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
